/* hw/rtl/cdq_pkg.sv */
package cdq_pkg;

  // request codes
  localparam logic [1:0] ACT_PUSH_FRONT = 2'd0;
  localparam logic [1:0] ACT_PUSH_REAR  = 2'd1;
  localparam logic [1:0] ACT_POP_FRONT  = 2'd2;
  localparam logic [1:0] ACT_POP_REAR   = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_PUSH_FULL = 2'd1;
  localparam logic [1:0] ST_POP_EMPTY = 2'd2;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    CDQ_IDLE,
    CDQ_EXEC,
    CDQ_RESP
  } cdq_state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;    // capture request fields
    logic exec;     // update indexes, touch one slot
    logic respond;  // drive result strobe
  } cdq_cmd_t;

endpackage

/* hw/rtl/cdq_ctrl.sv */
module cdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output cdq_pkg::cdq_cmd_t cmd
);

  cdq_pkg::cdq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdq_pkg::CDQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cdq_pkg::CDQ_IDLE: begin
        if (start) state_nxt = cdq_pkg::CDQ_EXEC;
      end
      cdq_pkg::CDQ_EXEC: state_nxt = cdq_pkg::CDQ_RESP;
      cdq_pkg::CDQ_RESP: state_nxt = cdq_pkg::CDQ_IDLE;
      default:           state_nxt = cdq_pkg::CDQ_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      cdq_pkg::CDQ_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      cdq_pkg::CDQ_EXEC: cmd.exec    = 1'b1;
      cdq_pkg::CDQ_RESP: cmd.respond = 1'b1;
      default:           busy        = 1'b1;
    endcase
  end

  // a request always yields its strobe after the update state
  a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |-> ##2 cmd.respond)
    else $error("result strobe missing after request");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.latch, cmd.exec, cmd.respond}))
    else $error("overlapping controller commands");

  a_busy_resp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.respond |-> busy)
    else $error("not busy while responding");

endmodule

/* hw/rtl/cdq_datapath.sv */
module cdq_datapath #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cdq_pkg::cdq_cmd_t             cmd,
  input  logic [1:0]                    in_action,
  input  logic signed [cdq_pkg::WORD_W-1:0] in_push_value,
  output logic signed [cdq_pkg::WORD_W-1:0] out_pop_value,
  output logic [1:0]                    out_status,
  output logic                          out_is_empty,
  output logic                          out_is_full
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

  logic [cdq_pkg::WORD_W-1:0] mem [DEPTH];

  logic [1:0]                 act_r;
  logic [cdq_pkg::WORD_W-1:0] word_r;
  logic [IDX_W-1:0]           head_r, head_nxt;
  logic [IDX_W-1:0]           tail_r, tail_nxt;
  logic                       empty_r, empty_nxt;
  logic [1:0]                 status_r, status_nxt;
  logic                       pop_ok_r;
  logic [cdq_pkg::WORD_W-1:0] rd_data_r;

  logic             is_push, full, push_ok, pop_ok, front;
  logic [IDX_W-1:0] head_dn, tail_up, head_up, tail_dn;
  logic [IDX_W-1:0] wr_addr, rd_addr;

  always_comb begin
    head_up = (head_r == LAST) ? '0 : head_r + 1'b1;
    head_dn = (head_r == '0) ? LAST : head_r - 1'b1;
    tail_up = (tail_r == LAST) ? '0 : tail_r + 1'b1;
    tail_dn = (tail_r == '0) ? LAST : tail_r - 1'b1;
  end

  assign full    = !empty_r && (tail_up == head_r);
  assign is_push = (act_r == cdq_pkg::ACT_PUSH_FRONT) || (act_r == cdq_pkg::ACT_PUSH_REAR);
  assign front   = (act_r == cdq_pkg::ACT_PUSH_FRONT) || (act_r == cdq_pkg::ACT_POP_FRONT);
  assign push_ok = is_push && !full;
  assign pop_ok  = !is_push && !empty_r;

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    empty_nxt  = empty_r;
    status_nxt = cdq_pkg::ST_DONE;
    wr_addr    = '0;
    rd_addr    = front ? head_r : tail_r;
    if (is_push) begin
      if (full) begin
        status_nxt = cdq_pkg::ST_PUSH_FULL;
      end else if (empty_r) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        empty_nxt = 1'b0;
      end else if (front) begin
        head_nxt = head_dn;
        wr_addr  = head_dn;
      end else begin
        tail_nxt = tail_up;
        wr_addr  = tail_up;
      end
    end else begin
      if (empty_r) begin
        status_nxt = cdq_pkg::ST_POP_EMPTY;
      end else if (head_r == tail_r) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        empty_nxt = 1'b1;
      end else if (front) begin
        head_nxt = head_up;
      end else begin
        tail_nxt = tail_dn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r  <= in_action;
      word_r <= in_push_value;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      pop_ok_r <= pop_ok;
    end
  end

  // slot store: at most one write or one registered read per request
  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok) begin
      mem[wr_addr] <= word_r;
    end
    if (cmd.exec && pop_ok) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_pop_value = (cmd.respond && pop_ok_r) ? rd_data_r : '0;
  assign out_status    = status_r;
  assign out_is_empty  = empty_r;
  assign out_is_full   = full;

  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (head_r == '0) && (tail_r == '0))
    else $error("empty with indexes off slot zero");

  a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.respond && status_r == cdq_pkg::ST_POP_EMPTY) |-> empty_r)
    else $error("pop refused while words held");

  a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.respond && status_r == cdq_pkg::ST_PUSH_FULL) |-> full)
    else $error("push refused while space left");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && push_ok) |=> !empty_r)
    else $error("empty after accepted push");

endmodule

/* hw/rtl/circular_deque_top.sv */
// Double-ended queue over a circular slot store of DEPTH words.
// A request taken at a start edge gives its result strobe after the update state.
// A new request is taken only while idle; busy spans the update cycle, in which
// the store is written or read at most once, then the response with registered data.
// Reset (rst_n, synchronous, low): deque empty, both indexes at slot zero; slot
// contents are left as they are. The receiver cannot stall: out_valid lasts one cycle.
module circular_deque_top #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_action,
  input  logic signed [cdq_pkg::WORD_W-1:0] in_push_value,
  output logic                              out_valid,
  output logic signed [cdq_pkg::WORD_W-1:0] out_pop_value,
  output logic [1:0]                        out_status,
  output logic                              out_is_empty,
  output logic                              out_is_full
);

  cdq_pkg::cdq_cmd_t cmd;

  // sequencer: idle -> update -> respond
  cdq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // indexes, empty flag and the slot store
  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_action     (in_action),
    .in_push_value (in_push_value),
    .out_pop_value (out_pop_value),
    .out_status    (out_status),
    .out_is_empty  (out_is_empty),
    .out_is_full   (out_is_full)
  );

  // one strobe per request
  assign out_valid = cmd.respond;

endmodule
